// ----- sv/psw_rl_pkg.sv -----
// Package for the per-source window rate limiter: word types, request and
// register codes, and the command and status structs between control and datapath.
// No dependencies.
`default_nettype none

package psw_rl_pkg;

    // request codes carried in req_type
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY_THRESHOLD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW_LEN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY_WINDOW_LEN = 4'd3;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [15:0] RATE_LIMIT_RST         = 16'd10;
    localparam logic [15:0] ANOMALY_THRESHOLD_RST  = 16'd50;
    localparam logic [31:0] RATE_WINDOW_LEN_RST    = 32'd1000;
    localparam logic [31:0] ANOMALY_WINDOW_LEN_RST = 32'd5000;

    // input word
    typedef struct packed {
        logic       req_type;
        logic [7:0] sender_id;
    } in_word_t;

    // result word
    typedef struct packed {
        logic       rate_exceeded;
        logic       anomaly_flag;
        logic [1:0] mitigation_drops;
    } out_word_t;

    // commands from the controller
    typedef struct packed {
        logic capture;   // take input word, start counter read
        logic update;    // apply the word and load the result register
        logic clr_step;  // clear one counter entry of the sweep
    } cmd_t;

    // status back to the controller
    typedef struct packed {
        logic is_tick;     // held word is a tick
        logic window_end;  // this tick ends at least one window
        logic clr_last;    // sweep is at its last entry
        logic out_free;    // result register can take a word this cycle
    } status_t;

endpackage

`default_nettype wire

// ----- sv/psw_rl_ctrl.sv -----
// Controller for the per-source window rate limiter: sequences accept,
// update and counter clearing sweeps. Depends on psw_rl_pkg.
`default_nettype none

module psw_rl_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  psw_rl_pkg::status_t status,
    output psw_rl_pkg::cmd_t   cmd
);
    import psw_rl_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.update   = 1'b0;
        cmd.clr_step = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    if (status.is_tick && status.window_end)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // state register, sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/psw_rl_datapath.sv -----
// Datapath for the per-source window rate limiter: configuration registers,
// per-sender counter memories, tick counters, clear sweep and result register.
// Depends on psw_rl_pkg.
`default_nettype none

module psw_rl_datapath #(
    parameter int NUM_SENDERS = 256,
    parameter int COUNT_BITS  = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_valid,
    input  wire  [psw_rl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [psw_rl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  psw_rl_pkg::in_word_t                   in_data,
    input  wire                                    out_stall,
    output logic                                   out_valid,
    output psw_rl_pkg::out_word_t                  out_data,
    input  psw_rl_pkg::cmd_t                       cmd,
    output psw_rl_pkg::status_t                    status
);
    import psw_rl_pkg::*;

    localparam int IDX_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SENDERS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration registers
    logic [15:0] rate_limit_reg;
    logic [15:0] anomaly_threshold_reg;
    logic [31:0] rate_window_len_reg;
    logic [31:0] anomaly_window_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg         <= RATE_LIMIT_RST;
            anomaly_threshold_reg  <= ANOMALY_THRESHOLD_RST;
            rate_window_len_reg    <= RATE_WINDOW_LEN_RST;
            anomaly_window_len_reg <= ANOMALY_WINDOW_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RATE_LIMIT:         rate_limit_reg         <= cfg_data[15:0];
                CFG_ANOMALY_THRESHOLD:  anomaly_threshold_reg  <= cfg_data[15:0];
                CFG_RATE_WINDOW_LEN:    rate_window_len_reg    <= cfg_data;
                CFG_ANOMALY_WINDOW_LEN: anomaly_window_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // held input word
    in_word_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
    end

    logic             item_in_range;
    logic [IDX_W-1:0] item_idx;
    logic [IDX_W-1:0] rd_idx;

    assign item_in_range = (32'(item_reg.sender_id) < NUM_SENDERS);
    assign item_idx      = IDX_W'(item_reg.sender_id);
    assign rd_idx        = IDX_W'(in_data.sender_id);

    // clear sweep state
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;
    logic             clr_short_reg;
    logic             clr_short_next;
    logic             clr_long_reg;
    logic             clr_long_next;

    // tick counters
    logic [31:0] short_tick_reg;
    logic [31:0] short_tick_next;
    logic [31:0] long_tick_reg;
    logic [31:0] long_tick_next;
    logic [31:0] short_tick_inc;
    logic [31:0] long_tick_inc;
    logic        short_end;
    logic        long_end;

    assign short_tick_inc = short_tick_reg + 32'd1;
    assign long_tick_inc  = long_tick_reg + 32'd1;
    assign short_end      = (short_tick_inc >= rate_window_len_reg);
    assign long_end       = (long_tick_inc >= anomaly_window_len_reg);

    // counter memories, read data registered
    logic [COUNT_BITS-1:0] mem_short [NUM_SENDERS];
    logic [COUNT_BITS-1:0] mem_long  [NUM_SENDERS];
    logic [COUNT_BITS-1:0] rd_short_reg;
    logic [COUNT_BITS-1:0] rd_long_reg;

    logic                  arrival_upd;
    logic                  short_we;
    logic                  long_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] short_inc;
    logic [COUNT_BITS-1:0] long_inc;
    logic [COUNT_BITS-1:0] short_wd;
    logic [COUNT_BITS-1:0] long_wd;

    assign short_inc = (rd_short_reg == COUNT_MAX) ? COUNT_MAX
                                                   : rd_short_reg + COUNT_BITS'(1);
    assign long_inc  = (rd_long_reg == COUNT_MAX) ? COUNT_MAX
                                                  : rd_long_reg + COUNT_BITS'(1);

    assign arrival_upd = cmd.update && (item_reg.req_type == REQ_ARRIVAL) && item_in_range;

    // write port shared by update and clear sweep
    always_comb
    begin
        if (cmd.clr_step)
        begin
            wr_addr  = clr_addr_reg;
            short_we = clr_short_reg;
            long_we  = clr_long_reg;
            short_wd = '0;
            long_wd  = '0;
        end
        else
        begin
            wr_addr  = item_idx;
            short_we = arrival_upd;
            long_we  = arrival_upd;
            short_wd = short_inc;
            long_wd  = long_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (short_we)
        begin
            mem_short[wr_addr] <= short_wd;
        end
        if (cmd.capture)
        begin
            rd_short_reg <= mem_short[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (long_we)
        begin
            mem_long[wr_addr] <= long_wd;
        end
        if (cmd.capture)
        begin
            rd_long_reg <= mem_long[rd_idx];
        end
    end

    // tick counter and sweep flag next values
    always_comb
    begin
        short_tick_next = short_tick_reg;
        long_tick_next  = long_tick_reg;
        clr_addr_next   = clr_addr_reg;
        clr_short_next  = clr_short_reg;
        clr_long_next   = clr_long_reg;
        if (cmd.update && (item_reg.req_type == REQ_TICK))
        begin
            short_tick_next = short_end ? 32'd0 : short_tick_inc;
            long_tick_next  = long_end ? 32'd0 : long_tick_inc;
            clr_addr_next   = '0;
            clr_short_next  = short_end;
            clr_long_next   = long_end;
        end
        else if (cmd.clr_step)
        begin
            if (clr_addr_reg == LAST_IDX)
            begin
                clr_addr_next  = '0;
                clr_short_next = 1'b0;
                clr_long_next  = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_tick_reg <= '0;
            long_tick_reg  <= '0;
            clr_addr_reg   <= '0;
            clr_short_reg  <= 1'b1;
            clr_long_reg   <= 1'b1;
        end
        else
        begin
            short_tick_reg <= short_tick_next;
            long_tick_reg  <= long_tick_next;
            clr_addr_reg   <= clr_addr_next;
            clr_short_reg  <= clr_short_next;
            clr_long_reg   <= clr_long_next;
        end
    end

    // result compare
    logic rate_hit;
    logic anom_hit;

    assign rate_hit = arrival_upd && (32'(short_inc) > 32'(rate_limit_reg));
    assign anom_hit = arrival_upd && (32'(long_inc) > 32'(anomaly_threshold_reg));

    // result register
    logic      out_valid_reg;
    out_word_t out_data_reg;
    logic      out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_data_reg.rate_exceeded    <= rate_hit;
            out_data_reg.anomaly_flag     <= anom_hit;
            out_data_reg.mitigation_drops <= 2'(rate_hit) + 2'(anom_hit);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status to the controller
    assign status.is_tick    = (item_reg.req_type == REQ_TICK);
    assign status.window_end = short_end || long_end;
    assign status.clr_last   = (clr_addr_reg == LAST_IDX);
    assign status.out_free   = out_free;

endmodule

`default_nettype wire

// ----- sv/per_source_window_rate_limiter_top.sv -----
// Per-source window rate limiter, top level: controller plus datapath.
// Depends on psw_rl_pkg, psw_rl_ctrl and psw_rl_datapath.
//
// Input words carry req_type (arrival or tick) and sender_id; each word gives
// exactly one result word with rate_exceeded, anomaly_flag, mitigation_drops.
// A word is taken when in_valid is high and in_stall low; a result is taken
// when out_valid is high and out_stall low. Configuration goes over cfg_valid,
// cfg_index, cfg_data; cfg_ready is always high, unknown indexes are ignored.
// Sequence: the sender's counters are read from memory at the edge that accepts
// the word, and the update and result load follow from the update state once
// the result register is free.
// A tick that ends a window starts a sweep that clears the counter memory of
// each window that ended, one entry per cycle, with in_stall high.
// After reset the same sweep clears both memories.
// The result register lets the next word be accepted while a result waits;
// a stalled receiver holds the block in the update step until the result
// register frees, and nothing is dropped.
`default_nettype none

module per_source_window_rate_limiter_top #(
    parameter int NUM_SENDERS = 256,
    parameter int COUNT_BITS  = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  psw_rl_pkg::in_word_t              in_data,
    output logic                              out_valid,
    input  wire                               out_stall,
    output psw_rl_pkg::out_word_t             out_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [psw_rl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [psw_rl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import psw_rl_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // sequencing
    psw_rl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, registers and result
    psw_rl_datapath #(
        .NUM_SENDERS (NUM_SENDERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- sim/tb_per_source_window_rate_limiter_top.sv -----
// Testbench for per_source_window_rate_limiter_top: drives arrival and tick words,
// predicts each result word from its own copy of the window counters and checks it.
// Depends on psw_rl_pkg and the rate limiter RTL.
`default_nettype none

module tb_per_source_window_rate_limiter_top;
    import psw_rl_pkg::*;

    localparam int NUM_SENDERS = 256;
    localparam int COUNT_BITS  = 16;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int HOT_RUN     = 30;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

    // window counter predictor and store of expected result words
    class window_scoreboard;
        logic [15:0] rate_limit;
        logic [15:0] anomaly_threshold;
        logic [31:0] rate_window_len;
        logic [31:0] anomaly_window_len;
        logic [COUNT_BITS-1:0] short_cnt [NUM_SENDERS];
        logic [COUNT_BITS-1:0] long_cnt [NUM_SENDERS];
        logic [31:0] short_ticks;
        logic [31:0] long_ticks;
        out_word_t expected_q [$];
        int errors;

        function new();
            rate_limit         = RATE_LIMIT_RST;
            anomaly_threshold  = ANOMALY_THRESHOLD_RST;
            rate_window_len    = RATE_WINDOW_LEN_RST;
            anomaly_window_len = ANOMALY_WINDOW_LEN_RST;
            foreach (short_cnt[s])
            begin
                short_cnt[s] = '0;
                long_cnt[s]  = '0;
            end
            short_ticks = '0;
            long_ticks  = '0;
            errors      = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RATE_LIMIT:         rate_limit = data[15:0];
                CFG_ANOMALY_THRESHOLD:  anomaly_threshold = data[15:0];
                CFG_RATE_WINDOW_LEN:    rate_window_len = data;
                CFG_ANOMALY_WINDOW_LEN: anomaly_window_len = data;
                default: ;
            endcase
        endfunction

        // accepted input word: update counters, queue the result it causes
        function void note_word(in_word_t w);
            out_word_t r;
            r = '0;
            if (w.req_type == REQ_TICK)
            begin
                // each window counts its ticks; at its length it clears all counts
                short_ticks = short_ticks + 1;
                if (short_ticks >= rate_window_len)
                begin
                    short_ticks = '0;
                    foreach (short_cnt[s])
                        short_cnt[s] = '0;
                end
                long_ticks = long_ticks + 1;
                if (long_ticks >= anomaly_window_len)
                begin
                    long_ticks = '0;
                    foreach (long_cnt[s])
                        long_cnt[s] = '0;
                end
            end
            else if (int'(w.sender_id) < NUM_SENDERS)
            begin
                // saturating increments, then compare against the limits
                if (short_cnt[w.sender_id] != COUNT_MAX)
                    short_cnt[w.sender_id] = short_cnt[w.sender_id] + 1'b1;
                if (long_cnt[w.sender_id] != COUNT_MAX)
                    long_cnt[w.sender_id] = long_cnt[w.sender_id] + 1'b1;
                r.rate_exceeded    = short_cnt[w.sender_id] > rate_limit;
                r.anomaly_flag     = long_cnt[w.sender_id] > anomaly_threshold;
                r.mitigation_drops = {1'b0, r.rate_exceeded} + {1'b0, r.anomaly_flag};
            end
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [1:0] exp_v, logic [1:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, exp_v, got_v);
        endfunction

        // accepted result word: compare with the oldest expectation
        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected, expected none, actual %b",
                         $time, got);
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.rate_exceeded !== exp_w.rate_exceeded)
                report("rate_exceeded", {1'b0, exp_w.rate_exceeded},
                       {1'b0, got.rate_exceeded});
            if (got.anomaly_flag !== exp_w.anomaly_flag)
                report("anomaly_flag", {1'b0, exp_w.anomaly_flag},
                       {1'b0, got.anomaly_flag});
            if (got.mitigation_drops !== exp_w.mitigation_drops)
                report("mitigation_drops", exp_w.mitigation_drops, got.mitigation_drops);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    window_scoreboard sb = new();
    int burst_left;
    logic [7:0] sender_pool [3];

    per_source_window_rate_limiter_top #(
        .NUM_SENDERS(NUM_SENDERS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_word(out_data);
    end

    // receiver stall pattern, changes character every stretch
    initial
    begin : receiver_stall
        stall_mode_e mode;
        int stretch;
        int period;
        int duty;
        int phase;
        out_stall = 1'b0;
        forever
        begin
            mode    = stall_mode_e'($urandom_range(0, 3));
            stretch = $urandom_range(20, 200);
            period  = $urandom_range(2, 24);
            duty    = $urandom_range(1, period - 1);
            phase   = 0;
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
                    STALL_PERIODIC: out_stall <= (phase < duty);
                    default:        out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                phase = (phase + 1) % period;
            end
        end
    end

    function automatic in_word_t make_word(logic kind, logic [7:0] id);
        in_word_t w;
        w.req_type  = kind;
        w.sender_id = id;
        return w;
    endfunction

    // random word: mostly arrivals from a few senders so that limits get crossed
    function automatic in_word_t rand_word();
        in_word_t w;
        w.req_type = ($urandom_range(0, 3) == 0) ? REQ_TICK : REQ_ARRIVAL;
        if ($urandom_range(0, 9) < 7)
            w.sender_id = sender_pool[$urandom_range(0, 2)];
        else
            w.sender_id = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // send one word, in bursts with random gaps between them
    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_word(w);
        burst_left--;
    endtask

    task automatic run_random(input int n);
        foreach (sender_pool[k])
            sender_pool[k] = 8'($urandom_range(0, 255));
        repeat (n)
            send_word(rand_word());
    endtask

    // stop sending, wait for all results and for any clearing sweep to end
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // one register write, cfg_valid left high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.apply_reg(idx, data);
    endtask

    task automatic set_config(input logic [31:0] rl, input logic [31:0] at,
                              input logic [31:0] rw, input logic [31:0] aw);
        cfg_write(CFG_RATE_LIMIT, rl);
        cfg_write(CFG_ANOMALY_THRESHOLD, at);
        cfg_write(CFG_RATE_WINDOW_LEN, rw);
        cfg_write(CFG_ANOMALY_WINDOW_LEN, aw);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // clearing sweep after reset
        do
            @(posedge clk);
        while (in_stall !== 1'b0);

        // reset settings: sender extremes, a tick, one sender past the rate limit
        send_word(make_word(REQ_ARRIVAL, 8'h00));
        send_word(make_word(REQ_ARRIVAL, 8'hFF));
        send_word(make_word(REQ_ARRIVAL, 8'h55));
        send_word(make_word(REQ_ARRIVAL, 8'hAA));
        send_word(make_word(REQ_TICK, 8'hFF));
        repeat (11)
            send_word(make_word(REQ_ARRIVAL, 8'h07));
        wait_idle();

        // zero-length short window, both windows ending on the same tick
        set_config(32'd1, 32'd2, 32'd0, 32'd2);
        send_word(make_word(REQ_ARRIVAL, 8'h09));
        send_word(make_word(REQ_ARRIVAL, 8'h09));
        send_word(make_word(REQ_ARRIVAL, 8'h09));
        send_word(make_word(REQ_TICK, 8'h09));
        send_word(make_word(REQ_ARRIVAL, 8'h09));
        send_word(make_word(REQ_TICK, 8'h00));
        send_word(make_word(REQ_ARRIVAL, 8'h09));
        wait_idle();

        // writes to unused indexes are dropped
        cfg_write(CFG_UNUSED_LO, 32'hFFFF_FFFF);
        cfg_write(CFG_UNUSED_HI, 32'h0000_0001);
        @(negedge clk);
        cfg_valid <= 1'b0;
        run_random(20);
        wait_idle();

        // lowest limits, one-tick windows
        set_config(32'd0, 32'd0, 32'd1, 32'd1);
        run_random(40);
        wait_idle();

        // longest windows, one sender pushed past both limits
        set_config(32'd5, 32'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (HOT_RUN)
            send_word(make_word(REQ_ARRIVAL, 8'h3C));
        run_random(20);
        wait_idle();

        // small random settings, last phase with full-width random data
        for (int p = 0; p < 6; p++)
        begin
            if (p == 5)
                set_config($urandom, $urandom, $urandom, $urandom);
            else
                set_config($urandom_range(0, 6), $urandom_range(0, 15),
                           ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10),
                           $urandom_range(1, 30));
            run_random(55);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/psw_rl_pkg.sv
sv/psw_rl_ctrl.sv
sv/psw_rl_datapath.sv
sv/per_source_window_rate_limiter_top.sv
sim/tb_per_source_window_rate_limiter_top.sv
